/* sv/ptla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptla_pkg
// Shared types and request codes for the page table with LRU ages.
// ----------------------------------------------------------------------------
package ptla_pkg;

  // Request codes carried on req_type_i
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_EVICT  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_FETCH,
    ST_RESP
  } ptla_state_e;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    logic touch;       // make the addressed entry newest, age the others
    logic make_valid;  // mark the addressed entry valid
    logic kill;        // invalidate the addressed entry
  } ptla_cmd_t;

endpackage : ptla_pkg
`default_nettype wire

/* sv/ptla_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptla_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : ptla_ram
`default_nettype wire

/* sv/ptla_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptla_cell
// One table entry: valid mark and saturating age, plus one stage of the
// oldest-entry search chain that runs from index 0 upwards.
// ----------------------------------------------------------------------------
module ptla_cell #(
  parameter int AGE_BITS = 8,
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ptla_pkg::ptla_cmd_t cmd_i,
  input  wire logic [IDX_W-1:0]    cmd_idx_i,
  input  wire logic                cand_found_i,
  input  wire logic [AGE_BITS-1:0] cand_age_i,
  input  wire logic [IDX_W-1:0]    cand_idx_i,
  output logic                     cand_found_o,
  output logic [AGE_BITS-1:0]      cand_age_o,
  output logic [IDX_W-1:0]         cand_idx_o,
  output logic                     valid_o
);
  import ptla_pkg::*;

  logic                valid_q, valid_d;
  logic [AGE_BITS-1:0] age_q, age_d;
  logic                found_q, found_d;
  logic [AGE_BITS-1:0] best_age_q, best_age_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic                mine;
  logic                take_own;

  assign mine = (cmd_idx_i == IDX_W'(CELL_IDX));

  // Entry update: refresh own age on touch, age others, drop on kill
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (cmd_i.touch) begin
      if (mine) begin
        age_d = '0;
        if (cmd_i.make_valid) begin
          valid_d = 1'b1;
        end
      end else if (valid_q && (age_q != {AGE_BITS{1'b1}})) begin
        age_d = age_q + 1'b1;
      end
    end
    if (cmd_i.kill && mine) begin
      valid_d = 1'b0;
      age_d   = '0;
    end
  end

  // Search stage: take this entry on a greater or equal age (highest index wins ties)
  assign take_own = valid_q && (!cand_found_i || (age_q >= cand_age_i));

  always_comb begin
    if (take_own) begin
      found_d    = 1'b1;
      best_age_d = age_q;
      best_idx_d = IDX_W'(CELL_IDX);
    end else begin
      found_d    = cand_found_i;
      best_age_d = cand_age_i;
      best_idx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
      found_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      found_q <= found_d;
    end
  end

  // Candidate payload, handed on to the next cell every cycle
  always_ff @(posedge clk_i) begin
    best_age_q <= best_age_d;
    best_idx_q <= best_idx_d;
  end

  assign cand_found_o = found_q;
  assign cand_age_o   = best_age_q;
  assign cand_idx_o   = best_idx_q;
  assign valid_o      = valid_q;

endmodule : ptla_cell
`default_nettype wire

/* sv/page_table_lru_age.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_lru_age
// Direct-indexed page table with a per-entry LRU age kept in a row of cells
// and page numbers held in a RAM.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_stall_o    req_type_i, page_index_i, phys_page_in_i
//   output    out_valid_o / out_stall_i  hit_o, phys_page_out_o, victim_valid_o,
//                                        eviction_seen_o
//
// Insert and unused codes go straight to the response; lookup first passes a
// fetch state (registered RAM read). For evict the oldest-entry search ripples one
// cell per cycle along the chain, then the victim's page is read from RAM.
// Reset clears all valid marks, ages and the eviction flag at once.
// A stalled output holds the result; one further item is taken and worked
// on meanwhile, its result waiting until the output register frees.
// ----------------------------------------------------------------------------
module page_table_lru_age #(
  parameter int NUM_PAGES = 64,
  parameter int PHYS_BITS = 16,
  parameter int AGE_BITS  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [5:0]  page_index_i,
  input  wire logic [15:0] phys_page_in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             hit_o,
  output logic [15:0]      phys_page_out_o,
  output logic             victim_valid_o,
  output logic             eviction_seen_o
);
  import ptla_pkg::*;

  localparam int IDX_W = $clog2(NUM_PAGES);

  ptla_state_e state_q, state_d;

  logic                 in_xfer;
  logic                 out_free;
  logic                 in_range;
  logic [IDX_W-1:0]     idx;
  logic                 lookup_hit;

  ptla_cmd_t            cmd;
  logic [IDX_W-1:0]     cmd_idx;
  logic [NUM_PAGES-1:0] valid_vec;

  logic                 cand_found [NUM_PAGES+1];
  logic [AGE_BITS-1:0]  cand_age   [NUM_PAGES+1];
  logic [IDX_W-1:0]     cand_idx   [NUM_PAGES+1];

  logic                 ram_we;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [PHYS_BITS-1:0] ram_rdata;

  logic [IDX_W-1:0]     scan_cnt_q, scan_cnt_d;
  logic                 scan_last;
  logic                 sel_q, sel_d;
  logic                 res_hit_q, res_hit_d;
  logic                 res_victim_q, res_victim_d;
  logic [PHYS_BITS-1:0] res_page_q, res_page_d;
  logic                 flag_q, flag_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic                 out_hit_q;
  logic [15:0]          out_page_q;
  logic                 out_victim_q;
  logic                 out_seen_q;

  // Handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Decode the index
  assign in_range   = (32'(page_index_i) < 32'(NUM_PAGES));
  assign idx        = IDX_W'(page_index_i);
  assign lookup_hit = in_range && valid_vec[idx];
  assign scan_last  = (scan_cnt_q == IDX_W'(NUM_PAGES - 1));

  // Row of entry cells
  assign cand_found[0] = 1'b0;
  assign cand_age[0]   = '0;
  assign cand_idx[0]   = '0;

  for (genvar g = 0; g < NUM_PAGES; g++) begin : g_cell
    ptla_cell #(
      .AGE_BITS (AGE_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .cmd_idx_i    (cmd_idx),
      .cand_found_i (cand_found[g]),
      .cand_age_i   (cand_age[g]),
      .cand_idx_i   (cand_idx[g]),
      .cand_found_o (cand_found[g+1]),
      .cand_age_o   (cand_age[g+1]),
      .cand_idx_o   (cand_idx[g+1]),
      .valid_o      (valid_vec[g])
    );
  end

  // Page number store
  ptla_ram #(
    .WIDTH (PHYS_BITS),
    .DEPTH (NUM_PAGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (PHYS_BITS'(phys_page_in_i)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (req_type_i)
            REQ_LOOKUP: state_d = ST_FETCH;
            REQ_EVICT:  state_d = ST_SCAN;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK:  state_d = ST_FETCH;
      ST_FETCH: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: cell commands, RAM access, result staging
  always_comb begin
    cmd          = '0;
    cmd_idx      = idx;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = idx;
    scan_cnt_d   = scan_cnt_q;
    sel_d        = sel_q;
    res_hit_d    = res_hit_q;
    res_victim_d = res_victim_q;
    res_page_d   = res_page_q;
    flag_d       = flag_q;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_hit_d    = 1'b0;
          res_victim_d = 1'b0;
          res_page_d   = '0;
          sel_d        = 1'b0;
          scan_cnt_d   = '0;
          case (req_type_i)
            REQ_INSERT: begin
              if (in_range) begin
                ram_we         = 1'b1;
                cmd.touch      = 1'b1;
                cmd.make_valid = 1'b1;
              end
            end
            REQ_LOOKUP: begin
              res_hit_d = lookup_hit;
              sel_d     = lookup_hit;
              ram_re    = lookup_hit;
              cmd.touch = lookup_hit;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        scan_cnt_d = scan_cnt_q + 1'b1;
      end
      ST_PICK: begin
        cmd_idx      = cand_idx[NUM_PAGES];
        ram_raddr    = cand_idx[NUM_PAGES];
        res_victim_d = cand_found[NUM_PAGES];
        sel_d        = cand_found[NUM_PAGES];
        if (cand_found[NUM_PAGES]) begin
          cmd.kill = 1'b1;
          ram_re   = 1'b1;
          flag_d   = 1'b1;
        end
      end
      ST_FETCH: begin
        res_page_d = sel_q ? ram_rdata : '0;
      end
      ST_RESP: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Output register: load on a free slot, drop after the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the working and result payload
  always_ff @(posedge clk_i) begin
    scan_cnt_q   <= scan_cnt_d;
    sel_q        <= sel_d;
    res_hit_q    <= res_hit_d;
    res_victim_q <= res_victim_d;
    res_page_q   <= res_page_d;
    if (out_load) begin
      out_hit_q    <= res_hit_q;
      out_page_q   <= 16'(res_page_q);
      out_victim_q <= res_victim_q;
      out_seen_q   <= flag_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign phys_page_out_o = out_page_q;
  assign victim_valid_o  = out_victim_q;
  assign eviction_seen_o = out_seen_q;

endmodule : page_table_lru_age
`default_nettype wire
